// ----- sv/ttyrx_pkg.sv -----
// Shared types and constants for the tty receive line buffer.
`timescale 1ns / 1ps

package ttyrx_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_ECHO  = 3'd1,
        KIND_INTR  = 3'd2,
        KIND_STOP  = 3'd3,
        KIND_BYTE  = 3'd4,
        KIND_EMPTY = 3'd5
    } kind_t;

    // Input commands
    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    // Control characters
    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_NL   = 8'h0a;
    localparam logic [7:0] CHAR_ETX  = 8'h03;
    localparam logic [7:0] CHAR_SUB  = 8'h1a;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GROUP_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_GROUP  = 2'd3;

    typedef struct packed {
        logic               canonical_mode;
        logic               echo_enable;
        logic               signal_enable;
        logic [GROUP_W-1:0] foreground_group;
    } cfg_t;

endpackage

// ----- sv/tty_receive_line_buffer_core.sv -----
// Top level: receive line discipline control around the ring memory.
`timescale 1ns / 1ps
// Receive transaction: a capture state, then a process state that writes its result
//   into the output register.
// Read transaction: capture, then a check state that issues the first ring read, then
//   the data state, which returns one byte per cycle while the output is not stalled, set by
//   the single registered read port of the ring memory. Empty read: capture, then check.
// Reset clears pointers, newline count and state and restores default settings; ring data is not cleared.

module tty_receive_line_buffer_core
    import ttyrx_pkg::*;
#(
    parameter int RING_DEPTH = 256,
    parameter int READ_LIMIT = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [7:0]            rx_char,
    input  logic [6:0]            read_count,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            kind,
    output logic [7:0]            data_byte,
    output logic [14:0]           signal_group,
    output logic                  dropped,
    output logic                  last,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(READ_LIMIT + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RX,
        S_RD_CHECK,
        S_RD_DATA
    } state_t;

    cfg_t cfg;

    // sequencer state
    state_t             state_reg, state_next;
    logic [7:0]         char_reg, char_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;

    // ring bookkeeping
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [PTR_W-1:0]   nl_cnt_reg, nl_cnt_next;   // newlines held in the ring

    // output register
    logic               out_valid_reg, out_valid_next;
    kind_t              kind_reg, kind_next;
    logic [7:0]         data_reg, data_next;
    logic [GROUP_W-1:0] group_reg, group_next;
    logic               dropped_reg, dropped_next;
    logic               last_reg, last_next;

    // memory port
    logic               mem_we;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [PTR_W-1:0]   mem_raddr;
    logic [7:0]         mem_rdata;

    logic [PTR_W-1:0]   wptr_adv;
    logic [PTR_W-1:0]   rptr_adv;
    logic               out_free;
    logic [CNT_W-1:0]   count_sat;
    logic [7:0]         rx_conv;
    logic               rx_is_sig;
    logic               ring_full;
    logic               read_none;
    logic               byte_last;

    ttyrx_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ttyrx_ring_ram #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wptr_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Pointer wrap handles depths that are not powers of two.
    assign wptr_adv = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
    assign rptr_adv = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    assign count_sat = (read_count > 7'(READ_LIMIT)) ? CNT_W'(READ_LIMIT)
                                                     : read_count[CNT_W-1:0];

    // Receive path decode; CR is folded to NL before anything else.
    assign rx_conv   = (char_reg == CHAR_CR) ? CHAR_NL : char_reg;
    assign rx_is_sig = (rx_conv == CHAR_ETX) || (rx_conv == CHAR_SUB);
    assign ring_full = (wptr_adv == rptr_reg);
    assign mem_wdata = rx_conv;

    // Canonical reads need a whole line; the newline count stands in for a scan.
    assign read_none = (remain_reg == '0) ||
                       (cfg.canonical_mode ? (nl_cnt_reg == '0) : (wptr_reg == rptr_reg));

    // Final byte: end of line, count used up, or ring drained in raw mode.
    assign byte_last = (cfg.canonical_mode && (mem_rdata == CHAR_NL)) ||
                       (remain_reg == CNT_W'(1)) ||
                       (!cfg.canonical_mode && (rptr_adv == wptr_reg));

    always_comb
    begin
        state_next     = state_reg;
        char_next      = char_reg;
        remain_next    = remain_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        nl_cnt_next    = nl_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        data_next      = data_reg;
        group_next     = group_reg;
        dropped_next   = dropped_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = rptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    char_next   = rx_char;
                    remain_next = count_sat;
                    state_next  = (command == CMD_READ) ? S_RD_CHECK : S_RX;
                end
            end

            S_RX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    data_next      = '0;
                    group_next     = '0;
                    dropped_next   = 1'b0;
                    kind_next      = KIND_NONE;
                    if (rx_is_sig)
                    begin
                        if (cfg.signal_enable && (cfg.foreground_group != '0))
                        begin
                            kind_next  = (rx_conv == CHAR_ETX) ? KIND_INTR : KIND_STOP;
                            group_next = cfg.foreground_group;
                        end
                    end
                    else
                    begin
                        dropped_next = ring_full;
                        if (!ring_full)
                        begin
                            mem_we    = 1'b1;
                            wptr_next = wptr_adv;
                            if (rx_conv == CHAR_NL)
                            begin
                                nl_cnt_next = nl_cnt_reg + 1'b1;
                            end
                        end
                        if (cfg.echo_enable)
                        begin
                            kind_next = KIND_ECHO;
                            data_next = rx_conv;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            S_RD_CHECK:
            begin
                if (read_none)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_EMPTY;
                        data_next      = '0;
                        group_next     = '0;
                        dropped_next   = 1'b0;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = rptr_reg;
                    state_next = S_RD_DATA;
                end
            end

            S_RD_DATA:
            begin
                // read data for rptr_reg is valid here
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_BYTE;
                    data_next      = mem_rdata;
                    group_next     = '0;
                    dropped_next   = 1'b0;
                    last_next      = byte_last;
                    rptr_next      = rptr_adv;
                    remain_next    = remain_reg - 1'b1;
                    if (mem_rdata == CHAR_NL)
                    begin
                        nl_cnt_next = nl_cnt_reg - 1'b1;
                    end
                    if (byte_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // fetch the following byte so it lands next cycle
                        mem_re    = 1'b1;
                        mem_raddr = rptr_adv;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            nl_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            nl_cnt_reg    <= nl_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        char_reg    <= char_next;
        remain_reg  <= remain_next;
        kind_reg    <= kind_next;
        data_reg    <= data_next;
        group_reg   <= group_next;
        dropped_reg <= dropped_next;
        last_reg    <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign data_byte    = data_reg;
    assign signal_group = group_reg;
    assign dropped      = dropped_reg;
    assign last         = last_reg;

endmodule

// ----- sv/ttyrx_ring_ram.sv -----
// Single-port-write, registered-read byte memory holding the receive ring.
`timescale 1ns / 1ps

module ttyrx_ring_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ttyrx_cfg_regs.sv -----
// Configuration register file: decodes writes and holds the line settings.
`timescale 1ns / 1ps

module ttyrx_cfg_regs
    import ttyrx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CANONICAL: cfg_next.canonical_mode   = cfg_data[0];
                CFG_ECHO:      cfg_next.echo_enable      = cfg_data[0];
                CFG_SIGNAL:    cfg_next.signal_enable    = cfg_data[0];
                CFG_FG_GROUP:  cfg_next.foreground_group = cfg_data[GROUP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.canonical_mode   <= 1'b1;
            cfg_reg.echo_enable      <= 1'b1;
            cfg_reg.signal_enable    <= 1'b1;
            cfg_reg.foreground_group <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/ttyrx_checker.sv -----
// Port-level checker for the tty receive line buffer, bound to the top level.
`timescale 1ns / 1ps

module ttyrx_checker
    import ttyrx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  data_byte,
    input logic [14:0] signal_group,
    input logic        dropped,
    input logic        last
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte) &&
            $stable(last))
        else $error("result changed while stalled");

    // Every non-byte result ends its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_BYTE) |-> last)
        else $error("single-result transaction not marked last");

    // Only echo and read bytes carry data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_ECHO) && (kind != KIND_BYTE) |-> data_byte == 8'd0)
        else $error("data on a kind without data");

    // No group and no dropped flag on read results.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_BYTE || kind == KIND_EMPTY) |->
            (signal_group == 15'd0) && !dropped)
        else $error("read result carries group or dropped flag");

endmodule

bind tty_receive_line_buffer_core ttyrx_checker u_ttyrx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .signal_group (signal_group),
    .dropped      (dropped),
    .last         (last)
);

// ----- bench/ttyrx_scoreboard_pkg.sv -----
// Line discipline predictor and result scoreboard for the tty receive line buffer bench.
`timescale 1ns / 1ps

package ttyrx_scoreboard_pkg;

    import ttyrx_pkg::*;

    localparam int BUF_DEPTH      = 256;
    localparam int BUF_READ_LIMIT = 64;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         data_byte;
        logic [GROUP_W-1:0] signal_group;
        logic               dropped;
        logic               last;
    } rx_result_t;

    class line_buffer_scoreboard;

        logic [7:0]  ring [BUF_DEPTH];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        cfg_t        cfg;
        rx_result_t  pending_q [$];

        int unsigned mismatches;
        int unsigned inputs_noted;
        int unsigned results_checked;
        int unsigned echo_count;
        int unsigned signal_count;
        int unsigned drop_count;
        int unsigned byte_count;
        int unsigned empty_count;

        function new();
            wr_ptr                 = 0;
            rd_ptr                 = 0;
            cfg.canonical_mode     = 1'b1;
            cfg.echo_enable        = 1'b1;
            cfg.signal_enable      = 1'b1;
            cfg.foreground_group   = '0;
            mismatches             = 0;
            inputs_noted           = 0;
            results_checked        = 0;
            echo_count             = 0;
            signal_count           = 0;
            drop_count             = 0;
            byte_count             = 0;
            empty_count            = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CANONICAL: cfg.canonical_mode   = val[0];
                CFG_ECHO:      cfg.echo_enable      = val[0];
                CFG_SIGNAL:    cfg.signal_enable    = val[0];
                CFG_FG_GROUP:  cfg.foreground_group = val[GROUP_W-1:0];
                default: ;
            endcase
        endfunction

        function void push(kind_t k, logic [7:0] d, logic [GROUP_W-1:0] g, logic drp,
                           logic lst);
            rx_result_t r;
            r.kind         = k;
            r.data_byte    = d;
            r.signal_group = g;
            r.dropped      = drp;
            r.last         = lst;
            pending_q.push_back(r);
            case (k)
                KIND_ECHO:            echo_count++;
                KIND_INTR, KIND_STOP: signal_count++;
                KIND_BYTE:            byte_count++;
                KIND_EMPTY:           empty_count++;
                default: ;
            endcase
            if (drp)
                drop_count++;
        endfunction

        function int unsigned stored_bytes();
            return (wr_ptr + BUF_DEPTH - rd_ptr) % BUF_DEPTH;
        endfunction

        // bytes up to and including the first buffered newline, 0 if none
        function int unsigned line_bytes();
            int unsigned n;
            int unsigned p;
            n = 0;
            p = rd_ptr;
            while (p != wr_ptr)
            begin
                n++;
                if (ring[p] == CHAR_NL)
                    return n;
                p = (p + 1) % BUF_DEPTH;
            end
            return 0;
        endfunction

        function void note_input(logic cmd, logic [7:0] ch, logic [6:0] cnt);
            logic [7:0]  c;
            logic        full;
            int unsigned nxt;
            int unsigned limit;
            int unsigned avail;
            inputs_noted++;
            if (cmd == CMD_RECEIVE)
            begin
                c = (ch == CHAR_CR) ? CHAR_NL : ch;
                if (c == CHAR_ETX || c == CHAR_SUB)
                begin
                    if (cfg.signal_enable && cfg.foreground_group != '0)
                        push((c == CHAR_ETX) ? KIND_INTR : KIND_STOP, 8'h00,
                             cfg.foreground_group, 1'b0, 1'b1);
                    else
                        push(KIND_NONE, 8'h00, '0, 1'b0, 1'b1);
                end
                else
                begin
                    nxt  = (wr_ptr + 1) % BUF_DEPTH;
                    full = (nxt == rd_ptr);
                    if (!full)
                    begin
                        ring[wr_ptr] = c;
                        wr_ptr       = nxt;
                    end
                    if (cfg.echo_enable)
                        push(KIND_ECHO, c, '0, full, 1'b1);
                    else
                        push(KIND_NONE, 8'h00, '0, full, 1'b1);
                end
            end
            else
            begin
                limit = (cnt > BUF_READ_LIMIT) ? BUF_READ_LIMIT : cnt;
                avail = cfg.canonical_mode ? line_bytes() : stored_bytes();
                if (limit == 0 || avail == 0)
                    push(KIND_EMPTY, 8'h00, '0, 1'b0, 1'b1);
                else
                begin
                    if (avail > limit)
                        avail = limit;
                    for (int i = 0; i < avail; i++)
                    begin
                        push(KIND_BYTE, ring[rd_ptr], '0, 1'b0, (i + 1 == avail));
                        rd_ptr = (rd_ptr + 1) % BUF_DEPTH;
                    end
                end
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void check_result(rx_result_t got);
            rx_result_t want;
            results_checked++;
            if (pending_q.size() == 0)
            begin
                flag($sformatf("unexpected result: kind %0d data %02h group %0d drop %0b last %0b",
                               got.kind, got.data_byte, got.signal_group, got.dropped,
                               got.last));
                return;
            end
            want = pending_q.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.signal_group !== want.signal_group || got.dropped !== want.dropped ||
                got.last !== want.last)
                flag($sformatf({"result %0d: want kind %0d data %02h group %0d drop %0b last %0b,",
                                " got kind %0d data %02h group %0d drop %0b last %0b"},
                               results_checked, want.kind, want.data_byte, want.signal_group,
                               want.dropped, want.last, got.kind, got.data_byte,
                               got.signal_group, got.dropped, got.last));
        endfunction

    endclass

endpackage

// ----- bench/tty_receive_line_buffer_core_test.sv -----
// Self-checking bench for the tty receive line buffer: directed, ring fill and random traffic.
`timescale 1ns / 1ps

module tty_receive_line_buffer_core_test;

    import ttyrx_pkg::*;
    import ttyrx_scoreboard_pkg::*;

    // cycles allowed after the last result before a register write or the end check
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic                  command      = CMD_RECEIVE;
    logic [7:0]            rx_char      = 8'h00;
    logic [6:0]            read_count   = 7'd0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [2:0]            kind;
    logic [7:0]            data_byte;
    logic [14:0]           signal_group;
    logic                  dropped;
    logic                  last;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_CANONICAL;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // calm: no gaps on the input side and no stalls on the result side
    bit                    calm         = 1'b0;
    int unsigned           reg_writes   = 0;

    line_buffer_scoreboard sb = new();

    tty_receive_line_buffer_core #(
        .RING_DEPTH (BUF_DEPTH),
        .READ_LIMIT (BUF_READ_LIMIT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .rx_char      (rx_char),
        .read_count   (read_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .signal_group (signal_group),
        .dropped      (dropped),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap / stall length: mostly zero or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly printable text, with some control and arbitrary bytes.
    function automatic logic [7:0] text_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 8'($urandom_range(8'h20, 8'h7e));
        if (r < 84)
            return CHAR_ETX;
        if (r < 88)
            return CHAR_SUB;
        return 8'($urandom_range(0, 255));
    endfunction

    // Any byte that is stored and is not a line end.
    function automatic logic [7:0] fill_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CHAR_CR || b == CHAR_NL || b == CHAR_ETX || b == CHAR_SUB)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [6:0] read_amount();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 7'($urandom_range(1, 12));
        if (r < 70)
            return 7'd0;
        if (r < 85)
            return 7'($urandom_range(BUF_READ_LIMIT, 127));
        return 7'($urandom_range(0, 127));
    endfunction

    // Result side: random backpressure, sampled with pre-edge values.
    initial
    begin
        int unsigned hold;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) < 25)
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
        end
    end

    // Every result transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin
        rx_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind         = kind;
            got.data_byte    = data_byte;
            got.signal_group = signal_group;
            got.dropped      = dropped;
            got.last         = last;
            sb.check_result(got);
        end
    end

    // One input transaction. Called at a rising edge; returns at the accepting edge
    // with valid still high, so a following transaction can go back to back.
    task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [6:0] cnt);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        rx_char    <= ch;
        read_count <= cnt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(cmd, ch, cnt);
    endtask

    // unused field carries random bits so every input bit toggles
    task automatic send_receive(input logic [7:0] ch);
        send_item(CMD_RECEIVE, ch, 7'($urandom_range(0, 127)));
    endtask

    task automatic send_read(input logic [6:0] cnt);
        send_item(CMD_READ, 8'($urandom_range(0, 255)), cnt);
    endtask

    // Every expected result has arrived, plus a settling wait for the block to go idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
        reg_writes++;
    endtask

    // Short directed sequence starting from reset settings
    // (canonical, echo on, signals on, no foreground group).
    task automatic directed_items();
        send_read(7'd5);                // empty ring
        send_receive("h");
        send_receive("i");
        send_read(7'd127);              // canonical, no complete line yet
        send_receive(CHAR_CR);          // carriage return echoes as newline
        send_read(7'd0);                // zero count
        send_read(7'd2);                // partial line
        send_read(7'd127);              // rest of the line, count saturated
        send_receive(CHAR_ETX);         // signals on but no group: nothing
        send_receive(CHAR_SUB);
        write_reg(CFG_FG_GROUP, 16'hffff);  // top bit masked, group 7fff
        send_receive(CHAR_ETX);         // interrupt
        send_receive(CHAR_SUB);         // stop
        write_reg(CFG_SIGNAL, 16'h0000);
        send_receive(CHAR_ETX);         // group set but signals off
        write_reg(CFG_SIGNAL, 16'hfffd);
        write_reg(CFG_FG_GROUP, 16'h0001);
        send_receive(CHAR_SUB);
        write_reg(CFG_ECHO, 16'hfffe);  // echo off
        send_receive(8'h00);
        send_receive(8'hff);
        write_reg(CFG_CANONICAL, 16'h0000);  // raw
        send_read(7'd1);
        send_read(7'd64);
        send_read(7'd3);                // raw, drained
        write_reg(CFG_ECHO, 16'h0001);
        send_receive(CHAR_NL);
        send_read(7'd127);
    endtask

    // Overflow the ring, check the drop flag with echo off and on, check that a
    // full ring with no line end reads empty in canonical mode, then drain it
    // in raw mode with saturated counts. Pointers wrap on the way.
    task automatic fill_and_drain();
        write_reg(CFG_CANONICAL, 16'h0001);
        write_reg(CFG_ECHO, 16'h0000);
        repeat (BUF_DEPTH + 1) send_receive(fill_byte());
        write_reg(CFG_ECHO, 16'h0001);
        repeat (2) send_receive(fill_byte());
        send_read(7'd127);
        write_reg(CFG_CANONICAL, 16'h0000);
        send_read(7'd127);
        send_read(7'd65);
        send_read(7'd64);
        send_read(7'd127);
        send_read(7'd1);
    endtask

    // New settings for a random phase; phase 0 is all ones, phase 1 all zeros.
    // Unused upper data bits are random to exercise register masking.
    task automatic shuffle_settings(input int ph);
        logic [CFG_DATA_W-1:0] noise;
        logic                  canon;
        logic                  echo_on;
        logic                  sig_on;
        logic [GROUP_W-1:0]    grp;
        int unsigned           r;
        noise = 16'($urandom);
        if (ph == 0)
        begin
            canon   = 1'b1;
            echo_on = 1'b1;
            sig_on  = 1'b1;
            grp     = '1;
        end
        else if (ph == 1)
        begin
            canon   = 1'b0;
            echo_on = 1'b0;
            sig_on  = 1'b0;
            grp     = '0;
        end
        else
        begin
            canon   = 1'($urandom_range(0, 1));
            echo_on = 1'($urandom_range(0, 1));
            sig_on  = ($urandom_range(0, 3) != 0);
            r       = $urandom_range(0, 3);
            grp     = (r == 0) ? '0 : (r == 1) ? GROUP_W'(1) : GROUP_W'($urandom);
        end
        write_reg(CFG_CANONICAL, {noise[15:1], canon});
        write_reg(CFG_ECHO, {noise[15:1], echo_on});
        write_reg(CFG_SIGNAL, {noise[15:1], sig_on});
        write_reg(CFG_FG_GROUP, {noise[15], grp});
    endtask

    // Random traffic: in canonical mode mostly whole lines followed by a read,
    // in raw mode bursts of text followed by a read, the rest single noise items.
    task automatic random_phase(input int n);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                len = $urandom_range(0, 6);
                repeat (len) send_receive(text_byte());
                if (sb.cfg.canonical_mode)
                begin
                    send_receive($urandom_range(0, 1) ? CHAR_CR : CHAR_NL);
                    sent++;
                end
                send_read(read_amount());
                sent += len + 1;
            end
            else
            begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        fill_and_drain();
        for (int ph = 0; ph < 7; ph++)
        begin
            shuffle_settings(ph);
            calm = (ph == 3);   // one stretch with no idling at all
            random_phase(6);
        end
        calm = 1'b0;

        // all stimulus accepted: wait out the results, then watch for strays
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input transactions, %0d results, %0d register writes",
                 sb.inputs_noted, sb.results_checked, reg_writes);
        $display("  %0d echoes, %0d signal events, %0d drops, %0d read bytes, %0d empty reads",
                 sb.echo_count, sb.signal_count, sb.drop_count, sb.byte_count,
                 sb.empty_count);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hang guard, several times the slowest legal run.
    initial
    begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
